/* sv/mafs_pkg.sv */
// mafs_pkg: shared types, constants and header tables of the audio frame splitter
// no dependencies; imported by every module of the block

package mafs_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int LEN_W = 11;
	localparam int RATE_W = 9;
	localparam int SR_W = 16;
	localparam int REM_W = 26;
	localparam int DIV_STEPS = LEN_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int LEFT_W = 29;

	localparam logic [17:0] LEN_K_V1 = 18'd144000;
	localparam logic [17:0] LEN_K_V2 = 18'd72000;
	localparam logic [LEN_W-1:0] SPF_V1 = 11'd1152;
	localparam logic [LEN_W-1:0] SPF_V2 = 11'd576;

	localparam logic [1:0] VER_MPEG1 = 2'd3;
	localparam logic [1:0] VER_RESERVED = 2'd1;
	localparam logic [3:0] BI_FREE = 4'd0;
	localparam logic [3:0] BI_BAD = 4'd15;

	localparam logic [RATE_W-1:0] RATE_V1 [16] = '{
		9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
	localparam logic [RATE_W-1:0] RATE_V2 [16] = '{
		9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};
	localparam logic [SR_W-1:0] SRATE [4][4] = '{
		'{16'd11025, 16'd12000, 16'd8000, 16'd0},
		'{16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd22050, 16'd24000, 16'd16000, 16'd0},
		'{16'd44100, 16'd48000, 16'd32000, 16'd0}};

	typedef enum logic [1:0] {
		CMD_ONE,
		CMD_TWO,
		CMD_HDR
	} cmd_code_t;

	typedef struct packed {
		cmd_code_t code;
		logic [31:0] word;
		logic kind;
		logic last;
		logic [LEN_W-1:0] len;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic [LEN_W-1:0] quot;
	} div_stat_t;

	function automatic logic [1:0] ver_of(logic [31:0] h);
		return h[20:19];
	endfunction

	function automatic logic [SR_W-1:0] srate_of(logic [31:0] h);
		return SRATE[h[20:19]][h[11:10]];
	endfunction

	function automatic logic [RATE_W-1:0] bitrate_of(logic [31:0] h);
		return (h[20:19] == VER_MPEG1) ? RATE_V1[h[15:12]] : RATE_V2[h[15:12]];
	endfunction

	function automatic logic [LEN_W-1:0] spf_of(logic [31:0] h);
		return (h[20:19] == VER_MPEG1) ? SPF_V1 : SPF_V2;
	endfunction

	function automatic logic hdr_ok(logic [31:0] h);
		return (h[15:12] != BI_FREE) && (h[15:12] != BI_BAD) &&
			(h[20:19] != VER_RESERVED) && (srate_of(h) != '0);
	endfunction

endpackage

/* sv/mafs_if.sv */
// mafs_if: valid/ready channels of the audio frame splitter (byte in, result out)
// depends on nothing; used by mafs_front, mafs_back and the top level

interface mafs_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic stream_start;

	modport source (output valid, output data_byte, output stream_start, input ready);
	modport sink (input valid, input data_byte, input stream_start, output ready);
endinterface

interface mafs_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic byte_kind;
	logic frame_first;
	logic frame_last;
	logic [10:0] frame_length;
	logic [15:0] sample_rate;
	logic [10:0] samples_per_frame;
	logic [1:0] mpeg_version;
	logic padded;

	modport source (output valid, output out_byte, output byte_kind, output frame_first,
		output frame_last, output frame_length, output sample_rate,
		output samples_per_frame, output mpeg_version, output padded, input ready);
	modport sink (input valid, input out_byte, input byte_kind, input frame_first,
		input frame_last, input frame_length, input sample_rate,
		input samples_per_frame, input mpeg_version, input padded, output ready);
endinterface

/* sv/mafs_div.sv */
// mafs_div: iterative frame length divider, one quotient bit per cycle
// depends on mafs_pkg

module mafs_div import mafs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] word,
	output div_stat_t stat
);

	logic busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] dsh_q;
	logic [LEN_W-1:0] quot_q;
	logic [26:0] prod;
	logic ge;

	always_comb begin
		prod = 27'((ver_of(word) == VER_MPEG1) ? LEN_K_V1 : LEN_K_V2) * 27'(bitrate_of(word));
		ge = rem_q >= dsh_q;
	end

	assign stat.busy = busy_q;
	assign stat.quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= prod[REM_W-1:0];
			dsh_q <= {srate_of(word), (REM_W - SR_W)'(0)};
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[LEN_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

endmodule

/* sv/mafs_front.sv */
// mafs_front: byte parser (tag skip, sync hunt, header check, frame count)
// depends on mafs_pkg and mafs_if; drives mafs_div and feeds mafs_queue

module mafs_front import mafs_pkg::*; (
	input logic clk,
	input logic arst_n,
	mafs_in_if.sink stream,
	input logic q_full,
	output logic push,
	output cmd_t push_cmd,
	output logic div_start,
	output logic [31:0] div_word,
	input div_stat_t div_stat
);

	localparam logic [2:0] MODE_TAG = 3'd0;
	localparam logic [2:0] MODE_SKIP = 3'd1;
	localparam logic [2:0] MODE_HUNT = 3'd2;
	localparam logic [2:0] MODE_HEADER = 3'd3;
	localparam logic [2:0] MODE_FRAME = 3'd4;
	localparam logic [2:0] MODE_CALC = 3'd5;

	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_E = 8'h65;
	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_3 = 8'h33;
	localparam logic [7:0] SYNC = 8'hFF;

	logic [2:0] mode_q, m, m_n;
	logic [31:0] hb_q, hb, hb_n;
	logic [2:0] hc_q, hc, hc_n;
	logic [LEFT_W-1:0] left_q, left, left_n, left_d, size;
	logic flag_q, flag, flag_n;
	logic [31:0] word_q;
	logic accept, restart, mis, do_hunt, start_c;
	logic [2:0] hunt_hc, hc_inc;
	logic [7:0] b, want;
	logic [31:0] h;
	logic [LEN_W-1:0] len;

	assign stream.ready = (mode_q != MODE_CALC) && !q_full;
	assign accept = stream.valid && stream.ready;
	assign restart = accept && stream.stream_start;
	assign b = stream.data_byte;
	assign div_start = start_c;
	assign div_word = h;

	always_comb begin
		m = restart ? MODE_TAG : mode_q;
		hb = restart ? '0 : hb_q;
		hc = restart ? '0 : hc_q;
		left = restart ? '0 : left_q;
		flag = restart ? 1'b0 : flag_q;
		m_n = m;
		hb_n = hb;
		hc_n = hc;
		left_n = left;
		flag_n = flag;
		push = 1'b0;
		push_cmd = '0;
		push_cmd.code = CMD_ONE;
		push_cmd.word = {24'h0, b};
		start_c = 1'b0;
		mis = 1'b0;
		do_hunt = 1'b0;
		hunt_hc = hc;
		want = CH_D;
		size = '0;
		left_d = '0;
		hc_inc = hc + 3'd1;
		h = {hb[23:0], b};
		len = div_stat.quot + LEN_W'(word_q[9]);
		if (mode_q == MODE_CALC) begin
			if (!div_stat.busy && !q_full) begin
				push = 1'b1;
				push_cmd.code = CMD_HDR;
				push_cmd.word = word_q;
				push_cmd.kind = 1'b1;
				push_cmd.len = len;
				left_n = LEFT_W'(len) - LEFT_W'(4);
				m_n = MODE_FRAME;
			end
		end else if (accept) begin
			unique case (m)
				MODE_TAG: begin
					priority if (left == '0) begin
						if (b != CH_I && b != CH_E) mis = 1'b1;
						else hb_n = {24'h0, b};
					end else if (left == LEFT_W'(1)) begin
						want = (hb == {24'h0, CH_I}) ? CH_D : CH_A;
						if (b != want) mis = 1'b1;
					end else if (left == LEFT_W'(2)) begin
						if (b != CH_3) mis = 1'b1;
						else hb_n = '0;
					end else if (left == LEFT_W'(5)) begin
						flag_n = b[4];
					end else if (left >= LEFT_W'(6)) begin
						hb_n = {4'h0, hb[20:0], b[6:0]};
					end else begin
						hb_n = hb;
					end
					if (mis) begin
						do_hunt = 1'b1;
						hunt_hc = '0;
						m_n = MODE_HUNT;
						hb_n = '0;
						hc_n = '0;
						left_n = '0;
					end else begin
						push = 1'b1;
						left_n = left + LEFT_W'(1);
						if (left >= LEFT_W'(9)) begin
							size = LEFT_W'(hb_n[27:0]) + (flag_n ? LEFT_W'(10) : LEFT_W'(0));
							hb_n = '0;
							if (size == '0) begin
								m_n = MODE_HUNT;
								left_n = '0;
								hc_n = '0;
							end else begin
								m_n = MODE_SKIP;
								left_n = size;
							end
						end
					end
				end
				MODE_SKIP: begin
					left_d = (left != '0) ? left - LEFT_W'(1) : '0;
					left_n = left_d;
					if (left_d == '0) begin
						m_n = MODE_HUNT;
						hc_n = '0;
					end
					push = 1'b1;
				end
				MODE_HUNT: begin
					do_hunt = 1'b1;
				end
				MODE_HEADER: begin
					if (hc_inc < 3'd4) begin
						hb_n = h;
						hc_n = hc_inc;
					end else begin
						hb_n = '0;
						hc_n = '0;
						if (hdr_ok(h)) begin
							start_c = 1'b1;
							m_n = MODE_CALC;
						end else begin
							push = 1'b1;
							push_cmd.code = CMD_HDR;
							push_cmd.word = h;
							m_n = MODE_HUNT;
						end
					end
				end
				MODE_FRAME: begin
					left_d = (left != '0) ? left - LEFT_W'(1) : '0;
					left_n = left_d;
					push = 1'b1;
					push_cmd.kind = 1'b1;
					if (left_d == '0) begin
						push_cmd.last = 1'b1;
						m_n = MODE_HEADER;
						hc_n = '0;
						hb_n = '0;
					end
				end
				default: begin
					do_hunt = 1'b1;
					hunt_hc = '0;
					m_n = MODE_HUNT;
					hb_n = '0;
					hc_n = '0;
					left_n = '0;
				end
			endcase
			if (do_hunt) begin
				priority if (hunt_hc == 3'd1 && b[7:5] == 3'b111) begin
					hb_n = {16'h0, SYNC, b};
					hc_n = 3'd2;
					m_n = MODE_HEADER;
				end else if (hunt_hc == 3'd1) begin
					push = 1'b1;
					if (b == SYNC) begin
						push_cmd.word = {24'h0, SYNC};
						hc_n = 3'd1;
					end else begin
						push_cmd.code = CMD_TWO;
						hc_n = '0;
					end
				end else if (b == SYNC) begin
					hc_n = 3'd1;
				end else begin
					push = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TAG;
			hb_q <= '0;
			hc_q <= '0;
			left_q <= '0;
			flag_q <= 1'b0;
		end else begin
			mode_q <= m_n;
			hb_q <= hb_n;
			hc_q <= hc_n;
			left_q <= left_n;
			flag_q <= flag_n;
		end
	end

	always_ff @(posedge clk) begin
		if (start_c) begin
			word_q <= h;
		end
	end

endmodule

/* sv/mafs_queue.sv */
// mafs_queue: small command queue between the parser and the result stage
// depends on mafs_pkg

module mafs_queue import mafs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cmd_t push_cmd,
	output logic full,
	input logic pop,
	output cmd_t head,
	output logic empty
);

	cmd_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full = cnt_q == QCNT_W'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_W'(1);
			if (pop) rd_q <= rd_q + QPTR_W'(1);
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + QCNT_W'(1);
				2'b01: cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* sv/mafs_back.sv */
// mafs_back: expands queued commands into result items behind an output register
// depends on mafs_pkg and mafs_if

module mafs_back import mafs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_t head,
	input logic empty,
	output logic pop,
	mafs_out_if.source result
);

	cmd_t cmd_q;
	logic [1:0] idx_q;
	logic busy_q;
	logic ov_q;
	logic [LEN_W-1:0] fi_len_q;
	logic [SR_W-1:0] fi_rate_q;
	logic [LEN_W-1:0] fi_spf_q;
	logic [1:0] fi_ver_q;
	logic fi_pad_q;
	logic [7:0] byte_q;
	logic kind_q, first_q, last_q;
	logic [LEN_W-1:0] len_q;
	logic [SR_W-1:0] rate_q;
	logic [LEN_W-1:0] spf_q;
	logic [1:0] ver_q;
	logic pad_q;

	logic emitting, fin;
	logic [1:0] last_idx;
	logic [7:0] b;
	logic k, first, last;

	always_comb begin
		b = cmd_q.word[7:0];
		k = 1'b0;
		first = 1'b0;
		last = 1'b0;
		last_idx = 2'd0;
		unique case (cmd_q.code)
			CMD_ONE: begin
				k = cmd_q.kind;
				last = cmd_q.last;
			end
			CMD_TWO: begin
				last_idx = 2'd1;
				if (idx_q == 2'd0) b = 8'hFF;
			end
			CMD_HDR: begin
				last_idx = 2'd3;
				k = cmd_q.kind;
				first = cmd_q.kind && (idx_q == 2'd0);
				unique case (idx_q)
					2'd0: b = cmd_q.word[31:24];
					2'd1: b = cmd_q.word[23:16];
					2'd2: b = cmd_q.word[15:8];
					default: b = cmd_q.word[7:0];
				endcase
			end
			default: begin
				last_idx = 2'd0;
			end
		endcase
		emitting = busy_q && (!ov_q || result.ready);
		fin = emitting && (idx_q == last_idx);
		pop = (!busy_q || fin) && !empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (fin) begin
				busy_q <= 1'b0;
			end else if (emitting) begin
				idx_q <= idx_q + 2'd1;
			end
			if (emitting) ov_q <= 1'b1;
			else if (result.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
			if (head.code == CMD_HDR && head.kind) begin
				fi_len_q <= head.len;
				fi_rate_q <= srate_of(head.word);
				fi_spf_q <= spf_of(head.word);
				fi_ver_q <= ver_of(head.word);
				fi_pad_q <= head.word[9];
			end
		end
		if (emitting) begin
			byte_q <= b;
			kind_q <= k;
			first_q <= first;
			last_q <= last;
			len_q <= k ? fi_len_q : '0;
			rate_q <= k ? fi_rate_q : '0;
			spf_q <= k ? fi_spf_q : '0;
			ver_q <= k ? fi_ver_q : '0;
			pad_q <= k && fi_pad_q;
		end
	end

	assign result.valid = ov_q;
	assign result.out_byte = byte_q;
	assign result.byte_kind = kind_q;
	assign result.frame_first = first_q;
	assign result.frame_last = last_q;
	assign result.frame_length = len_q;
	assign result.sample_rate = rate_q;
	assign result.samples_per_frame = spf_q;
	assign result.mpeg_version = ver_q;
	assign result.padded = pad_q;

endmodule

/* sv/mpeg_audio_frame_splitter_unit.sv */
// mpeg_audio_frame_splitter_unit: top level of the audio frame splitter
// depends on mafs_pkg, mafs_if, mafs_front, mafs_div, mafs_queue, mafs_back
//
// Takes one stream byte per cycle and returns one result item per byte, each marked as
// frame byte or discarded byte, with the current frame's length, sample rate, samples per
// frame, version and padding on frame bytes. A leading ID3/ea3 tag is skipped, then the
// stream is cut into frames at valid headers. Bytes are taken at one per cycle while the queue
// has room, except after the fourth byte of a valid header: the frame length comes from an
// 11-step shift-subtract divider. Results leave one per cycle from an output register while
// result.ready is high; a header yields four items, and a held sync byte may yield two items
// for one byte, which a four-entry command queue absorbs. A stream_start byte restarts parsing.

module mpeg_audio_frame_splitter_unit import mafs_pkg::*; (
	input logic clk,
	input logic arst_n,
	mafs_in_if.sink stream,
	mafs_out_if.source result
);

	logic push, pop, q_full, q_empty, div_start;
	cmd_t push_cmd, head;
	logic [31:0] div_word;
	div_stat_t div_stat;

	mafs_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.stream (stream),
		.q_full (q_full),
		.push (push),
		.push_cmd (push_cmd),
		.div_start (div_start),
		.div_word (div_word),
		.div_stat (div_stat)
	);

	mafs_div u_div (
		.clk (clk),
		.arst_n (arst_n),
		.start (div_start),
		.word (div_word),
		.stat (div_stat)
	);

	mafs_queue u_queue (
		.clk (clk),
		.arst_n (arst_n),
		.push (push),
		.push_cmd (push_cmd),
		.full (q_full),
		.pop (pop),
		.head (head),
		.empty (q_empty)
	);

	mafs_back u_back (
		.clk (clk),
		.arst_n (arst_n),
		.head (head),
		.empty (q_empty),
		.pop (pop),
		.result (result)
	);

endmodule
